FILE: hw/rtl/bsr_pkg.sv
// Package for the byte stream reassembler: status and action codes,
// controller states and the command/status structs between modules.
// No dependencies.
`default_nettype none
package bsr_pkg;

  localparam int unsigned RingDepthDef = 4096;
  localparam int unsigned CapWidth     = 13;
  localparam int unsigned CapResetVal  = 4096;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_READ = 2'd1,
    ACT_END  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_HELD       = 3'd1,
    ST_DUP        = 3'd2,
    ST_OUTWIN     = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5,
    ST_END        = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_PDEC,
    S_AREQ,
    S_AVAL,
    S_RDATA,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;    // write a zero mark during the clearing pass
    logic take_in;   // latch the input item
    logic chk;       // classify the item, issue the first memory reads
    logic pdec;      // push decision: store byte and mark if slot free
    logic adv_rd;    // read the mark at the next expected slot
    logic adv_clr;   // consume the next expected slot
    logic rd_take;   // capture the popped byte
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    clr_last;
    action_e act;
    logic    push_ok;   // push neither duplicate nor out of window
    logic    rd_avail;
    logic    mark_rd;   // registered mark read
    logic    ne_max;    // next expected offset saturated
    logic    out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bsr_ctrl.sv
// Controller of the byte stream reassembler: sequences clearing, push
// checks, the advance loop, reads and result hand-off.
// Depends on bsr_pkg.
`default_nettype none
module bsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsr_pkg::sts_t sts_i,
  output bsr_pkg::cmd_t cmd_o
);
  import bsr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        case (sts_i.act)
          ACT_PUSH: state_d = sts_i.push_ok ? S_PDEC : S_DONE;
          ACT_READ: state_d = sts_i.rd_avail ? S_RDATA : S_DONE;
          default:  state_d = S_DONE;
        endcase
      end
      S_PDEC:  state_d = sts_i.mark_rd ? S_DONE : S_AREQ;
      S_AREQ:  state_d = sts_i.ne_max ? S_DONE : S_AVAL;
      S_AVAL:  state_d = sts_i.mark_rd ? S_AREQ : S_DONE;
      S_RDATA: state_d = S_DONE;
      S_DONE:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take_in = in_valid_i;
      end
      S_CHECK: cmd_o.chk = 1'b1;
      S_PDEC:  cmd_o.pdec = 1'b1;
      S_AREQ:  cmd_o.adv_rd = !sts_i.ne_max;
      S_AVAL:  cmd_o.adv_clr = sts_i.mark_rd;
      S_RDATA: cmd_o.rd_take = 1'b1;
      S_DONE:  cmd_o.load_out = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // Items are only taken once the clearing pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("item taken during clearing pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_in) |=> (state_q == S_CHECK))
    else $error("accepted item not checked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !sts_i.out_free) |=> (state_q == S_DONE))
    else $error("result dropped while output full");

endmodule
`default_nettype wire

FILE: hw/rtl/bsr_dp.sv
// Datapath of the byte stream reassembler: byte ring and mark memories,
// offsets, counters, window test and the output register.
// Depends on bsr_pkg.
`default_nettype none
module bsr_dp #(
  parameter int unsigned RING_DEPTH = bsr_pkg::RingDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 action_i,
  input  logic [31:0]                stream_offset_i,
  input  logic [7:0]                 byte_value_i,
  input  logic                       window_capacity_we_i,
  input  logic [bsr_pkg::CapWidth-1:0] window_capacity_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [2:0]                 status_o,
  output logic [7:0]                 read_byte_o,
  output logic [12:0]                assembled_count_o,
  output logic [12:0]                unassembled_count_o,
  output logic                       stream_ended_o,
  input  bsr_pkg::cmd_t              cmd_i,
  output bsr_pkg::sts_t              sts_o
);
  import bsr_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned PW = AW + 1;

  // Memories
  logic [7:0] byte_mem [RING_DEPTH];
  logic       mark_mem [RING_DEPTH];

  logic [CapWidth-1:0] cap_q;
  logic [1:0]          act_q;
  logic [31:0]         off_q;
  logic [7:0]          val_q;
  logic [31:0]         ne_q, rp_q, end_off_q;
  logic                end_seen_q;
  logic [PW-1:0]       pend_q;
  logic [AW-1:0]       clr_q;
  logic [2:0]          stat_q;
  logic [7:0]          rbyte_q;
  logic                mark_rd_q;
  logic [7:0]          byte_rd_q;
  logic                out_valid_q;

  // Window test
  logic [31:0] cap_ext, eff_cap;
  logic [32:0] limit;
  logic        dup, outwin, rd_avail;
  assign cap_ext  = 32'(cap_q);
  assign eff_cap  = (cap_ext > 32'(RING_DEPTH)) ? 32'(RING_DEPTH) : cap_ext;
  assign limit    = {1'b0, rp_q} + {1'b0, eff_cap};
  assign dup      = off_q < ne_q;
  assign outwin   = ({1'b0, off_q} >= limit) || (off_q == '1);
  assign rd_avail = rp_q < ne_q;

  logic [2:0] chk_stat;
  always_comb begin
    case (action_e'(act_q))
      ACT_PUSH: chk_stat = dup ? ST_DUP : (outwin ? ST_OUTWIN : ST_STORED);
      ACT_READ: chk_stat = rd_avail ? ST_READ_OK : ST_READ_EMPTY;
      ACT_END:  chk_stat = ST_END;
      default:  chk_stat = ST_READ_EMPTY;
    endcase
  end

  // Mark memory port
  logic [AW-1:0] m_addr;
  logic          m_we, m_wd;
  always_comb begin
    m_addr = ne_q[AW-1:0];
    m_we   = 1'b0;
    m_wd   = 1'b0;
    if (cmd_i.clr_wr) begin
      m_addr = clr_q;
      m_we   = 1'b1;
    end else if (cmd_i.chk || cmd_i.pdec) begin
      m_addr = off_q[AW-1:0];
      m_we   = cmd_i.pdec && !mark_rd_q;
      m_wd   = 1'b1;
    end else if (cmd_i.adv_rd || cmd_i.adv_clr) begin
      m_addr = ne_q[AW-1:0];
      m_we   = cmd_i.adv_clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mark_mem[m_addr] <= m_wd;
    mark_rd_q <= mark_mem[m_addr];
  end

  // Byte memory port: write on store, read at the read position
  always_ff @(posedge clk_i) begin
    if (cmd_i.pdec && !mark_rd_q) byte_mem[off_q[AW-1:0]] <= val_q;
    byte_rd_q <= byte_mem[rp_q[AW-1:0]];
  end

  // Input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      act_q <= action_i;
      off_q <= stream_offset_i;
      val_q <= byte_value_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CapWidth'(CapResetVal);
      ne_q       <= '0;
      rp_q       <= '0;
      end_off_q  <= '0;
      end_seen_q <= 1'b0;
      pend_q     <= '0;
      clr_q      <= '0;
      stat_q     <= '0;
      rbyte_q    <= '0;
    end else begin
      if (window_capacity_we_i) cap_q <= window_capacity_i;
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      if (cmd_i.take_in) rbyte_q <= '0;
      if (cmd_i.chk) begin
        stat_q <= chk_stat;
        if (act_q == ACT_END) begin
          end_seen_q <= 1'b1;
          end_off_q  <= off_q;
        end
      end
      if (cmd_i.pdec) begin
        if (mark_rd_q) begin
          stat_q <= ST_HELD;
        end else begin
          pend_q <= pend_q + 1'b1;
        end
      end
      if (cmd_i.adv_clr) begin
        if (pend_q != '0) pend_q <= pend_q - 1'b1;
        ne_q <= ne_q + 32'd1;
      end
      if (cmd_i.rd_take) begin
        rbyte_q <= byte_rd_q;
        rp_q    <= rp_q + 32'd1;
      end
    end
  end

  // Output register
  logic [31:0] asm_cnt, pend_ext;
  assign asm_cnt  = ne_q - rp_q;
  assign pend_ext = 32'(pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o            <= stat_q;
      read_byte_o         <= rbyte_q;
      assembled_count_o   <= asm_cnt[12:0];
      unassembled_count_o <= pend_ext[12:0];
      stream_ended_o      <= end_seen_q && (ne_q >= end_off_q) && (pend_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = (clr_q == '1);
    sts_o.act      = action_e'(act_q);
    sts_o.push_ok  = !dup && !outwin;
    sts_o.rd_avail = rd_avail;
    sts_o.mark_rd  = mark_rd_q;
    sts_o.ne_max   = (ne_q == '1);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Read position never passes the next expected offset
  assert property (@(posedge clk_i) disable iff (!rst_ni) rp_q <= ne_q)
    else $error("read position beyond next expected");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ne_q - rp_q) <= 32'(RING_DEPTH))
    else $error("assembled bytes exceed ring");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_ext <= 32'(RING_DEPTH))
    else $error("pending count exceeds ring");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.adv_clr |=> (ne_q == $past(ne_q) + 32'd1))
    else $error("next expected did not advance");

endmodule
`default_nettype wire

FILE: hw/rtl/byte_stream_reassembler_unit.sv
// Top level of the byte stream reassembler: controller plus datapath.
// Depends on bsr_pkg, bsr_ctrl and bsr_dp.
//
// Takes push, read and end-mark items one at a time and returns one result
// item for each. After reset a clearing pass writes every slot of the mark
// memory, during which no item is taken. An accepted item is classified in
// the check state. An end mark, an empty read, an unused action and a push
// rejected as duplicate or out of window then go to the output register; a
// successful read first captures the popped byte; a push to an already held
// slot first passes the push decision; a stored push writes byte and mark,
// then advances the next expected offset over contiguous marked slots: the
// single-port mark memory is read then cleared once per slot. A result
// stalled at the output holds the controller until the output register is
// free, so the next item can be taken while a result waits to be collected.
`default_nettype none
module byte_stream_reassembler_unit #(
  parameter int unsigned RING_DEPTH = bsr_pkg::RingDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [31:0]                  stream_offset_i,
  input  logic [7:0]                   byte_value_i,
  input  logic                         window_capacity_we_i,
  input  logic [bsr_pkg::CapWidth-1:0] window_capacity_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [7:0]                   read_byte_o,
  output logic [12:0]                  assembled_count_o,
  output logic [12:0]                  unassembled_count_o,
  output logic                         stream_ended_o
);
  import bsr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsr_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .action_i             (action_i),
    .stream_offset_i      (stream_offset_i),
    .byte_value_i         (byte_value_i),
    .window_capacity_we_i (window_capacity_we_i),
    .window_capacity_i    (window_capacity_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .status_o             (status_o),
    .read_byte_o          (read_byte_o),
    .assembled_count_o    (assembled_count_o),
    .unassembled_count_o  (unassembled_count_o),
    .stream_ended_o       (stream_ended_o),
    .cmd_i                (cmd),
    .sts_o                (sts)
  );

endmodule
`default_nettype wire

FILE: verif/reassembly_checker.sv
`timescale 1ns / 1ps
// Checker for byte_stream_reassembler_unit: watches both item channels and the
// capacity register port, keeps its own reassembly state and compares results.
// Depends on bsr_pkg for the action and status codes.
module reassembly_checker #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] stream_offset_i,
  input  logic [7:0]  byte_value_i,
  input  logic        cap_we_i,
  input  logic [12:0] cap_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  read_byte_i,
  input  logic [12:0] assembled_count_i,
  input  logic [12:0] unassembled_count_i,
  input  logic        stream_ended_i,
  output int          fail_count_o,
  output int          waiting_o,
  output logic [31:0] read_pos_o
);
  import bsr_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [7:0]  rbyte;
    logic [12:0] asm_cnt;
    logic [12:0] una_cnt;
    logic        ended;
  } result_t;

  logic [7:0]  ring_bytes [RING_DEPTH];
  logic        ring_marks [RING_DEPTH];
  logic [31:0] next_off;
  logic [31:0] read_pos;
  logic [12:0] pending;
  logic        end_flag;
  logic [31:0] end_off;
  logic [12:0] capacity;
  result_t     expected_results [$];

  assign waiting_o  = expected_results.size();
  assign read_pos_o = read_pos;

  // Push one byte into the window, then advance over contiguous slots
  function automatic status_e push_byte(logic [31:0] off, logic [7:0] val);
    logic [32:0] limit;
    int unsigned slot;
    limit = {1'b0, read_pos} + ((capacity > RING_DEPTH) ? RING_DEPTH : capacity);
    if (off < next_off) return ST_DUP;
    if ({1'b0, off} >= limit || off == 32'hFFFF_FFFF) return ST_OUTWIN;
    slot = off % RING_DEPTH;
    if (ring_marks[slot]) return ST_HELD;
    ring_bytes[slot] = val;
    ring_marks[slot] = 1'b1;
    pending++;
    while (next_off != 32'hFFFF_FFFF && ring_marks[next_off % RING_DEPTH]) begin
      ring_marks[next_off % RING_DEPTH] = 1'b0;
      if (pending != 0) pending--;
      next_off++;
    end
    return ST_STORED;
  endfunction

  function automatic result_t reassemble_item(logic [1:0] act, logic [31:0] off,
                                              logic [7:0] val);
    result_t r;
    r.rbyte = 8'd0;
    case (act)
      ACT_PUSH: r.status = push_byte(off, val);
      ACT_READ: begin
        if (read_pos < next_off) begin
          r.rbyte  = ring_bytes[read_pos % RING_DEPTH];
          read_pos++;
          r.status = ST_READ_OK;
        end else begin
          r.status = ST_READ_EMPTY;
        end
      end
      ACT_END: begin
        end_flag = 1'b1;
        end_off  = off;
        r.status = ST_END;
      end
      default: r.status = ST_READ_EMPTY;
    endcase
    r.asm_cnt = 13'(next_off - read_pos);
    r.una_cnt = pending;
    r.ended   = end_flag && next_off >= end_off && pending == 0;
    return r;
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_marks[i] = 1'b0;
        ring_bytes[i] = 8'd0;
      end
      next_off = 0;
      read_pos = 0;
      pending  = 0;
      end_flag = 1'b0;
      end_off  = 0;
      capacity = 13'd4096;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.status  = status_e'(status_i);
        got.rbyte   = read_byte_i;
        got.asm_cnt = assembled_count_i;
        got.una_cnt = unassembled_count_i;
        got.ended   = stream_ended_i;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item status=%0d", $time, status_i);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch exp st=%0d rb=%h asm=%0d una=%0d end=%0d",
                     $time, exp_r.status, exp_r.rbyte, exp_r.asm_cnt,
                     exp_r.una_cnt, exp_r.ended);
            $display("%0t:          got st=%0d rb=%h asm=%0d una=%0d end=%0d",
                     $time, got.status, got.rbyte, got.asm_cnt,
                     got.una_cnt, got.ended);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(
          reassemble_item(action_i, stream_offset_i, byte_value_i));
      if (cap_we_i) capacity = cap_i;
    end
  end

endmodule

FILE: verif/tb_byte_stream_reassembler_unit.sv
`timescale 1ns / 1ps
// Testbench top for byte_stream_reassembler_unit: clock, reset, item stimulus
// and the verdict. Depends on bsr_pkg, the block and reassembly_checker.
module tb_byte_stream_reassembler_unit;
  import bsr_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_NONE;
  logic [31:0] stream_offset_i = '0;
  logic [7:0]  byte_value_i = '0;
  logic        window_capacity_we_i = 1'b0;
  logic [12:0] window_capacity_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  read_byte_o;
  logic [12:0] assembled_count_o;
  logic [12:0] unassembled_count_o;
  logic        stream_ended_o;

  int          fail_count;
  int          waiting;
  logic [31:0] read_pos;
  logic        in_taken = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic [12:0] cur_cap = 13'd4096;
  int unsigned cycles = 0;

  byte_stream_reassembler_unit dut (.*);

  reassembly_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i,
    .stream_offset_i, .byte_value_i, .cap_we_i(window_capacity_we_i),
    .cap_i(window_capacity_i), .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .read_byte_i(read_byte_o),
    .assembled_count_i(assembled_count_o),
    .unassembled_count_i(unassembled_count_o),
    .stream_ended_i(stream_ended_o), .fail_count_o(fail_count),
    .waiting_o(waiting), .read_pos_o(read_pos)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Acceptance flag, read back by the driver at the falling edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    cycles   <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** byte_stream_reassembler_unit: FAILED **");
      $finish;
    end
  end

  // Receiver stall
  always @(negedge clk_i) out_stall_i = ($urandom_range(99) < rx_idle_pct);

  task automatic send_item(logic [1:0] act, logic [31:0] off, logic [7:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    action_i        = act;
    stream_offset_i = off;
    byte_value_i    = val;
    do @(negedge clk_i); while (!in_taken);
    in_valid_i = 1'b0;
  endtask

  // Register write once every result is back
  task automatic write_capacity(logic [12:0] cap);
    while (waiting != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    window_capacity_we_i = 1'b1;
    window_capacity_i    = cap;
    cur_cap              = cap;
    @(negedge clk_i);
    window_capacity_we_i = 1'b0;
  endtask

  // Mostly pushes close to the read position, reads, and some noise
  task automatic random_item();
    int unsigned pick;
    int unsigned win;
    int unsigned span;
    pick = $urandom_range(99);
    win  = (cur_cap > 4096) ? 4096 : cur_cap;
    span = ($urandom_range(9) == 0) ? win + 2 : ((win < 48) ? win + 2 : 48);
    if (pick < 58)
      send_item(ACT_PUSH, read_pos + $urandom_range(span), 8'($urandom));
    else if (pick < 84)
      send_item(ACT_READ, $urandom, 8'($urandom));
    else if (pick < 89)
      send_item(ACT_END, read_pos + $urandom_range(64), 8'($urandom));
    else if (pick < 94)
      send_item(ACT_PUSH, $urandom, 8'($urandom));
    else if (pick < 97)
      send_item(ACT_NONE, $urandom, 8'($urandom));
    else
      send_item(ACT_PUSH, read_pos - $urandom_range(4), 8'($urandom));
  endtask

  initial begin
    logic [12:0] caps [6];
    caps = '{13'd8191, 13'd1, 13'd16, 13'd0, 13'd4096, 13'd300};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset capacity, ordering, duplicates, held bytes, end marks
    send_item(ACT_READ, 32'd0, 8'h00);
    send_item(ACT_PUSH, 32'd0, 8'hFF);
    send_item(ACT_PUSH, 32'd0, 8'h11);
    send_item(ACT_PUSH, 32'd2, 8'hA5);
    send_item(ACT_PUSH, 32'd2, 8'h5A);
    send_item(ACT_PUSH, 32'd1, 8'h00);
    send_item(ACT_READ, 32'd0, 8'h00);
    send_item(ACT_END, 32'hFFFF_FFFF, 8'h00);
    send_item(ACT_END, 32'd3, 8'h00);
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 8'h77);
    send_item(ACT_PUSH, 32'd5000, 8'h12);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 8'hFF);
    send_item(ACT_PUSH, 32'd10, 8'h3C);
    send_item(ACT_PUSH, 32'd4096, 8'h01);
    send_item(ACT_READ, 32'd0, 8'h00);
    send_item(ACT_READ, 32'd0, 8'h00);
    send_item(ACT_READ, 32'd0, 8'h00);
    // Shrink capacity while holding data, then zero capacity
    write_capacity(13'd1);
    send_item(ACT_PUSH, 32'd3, 8'hC3);
    send_item(ACT_PUSH, 32'd4, 8'h99);
    write_capacity(13'd0);
    send_item(ACT_PUSH, 32'd1, 8'h42);
    send_item(ACT_PUSH, 32'd20, 8'h42);
    send_item(ACT_READ, 32'd0, 8'h00);

    // Random phases over capacities and idling modes
    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      case (p % 3)
        0: begin tx_idle_pct = 33; rx_idle_pct = 83; end
        1: begin tx_idle_pct = 83; rx_idle_pct = 33; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (225) random_item();
    end

    while (waiting != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** byte_stream_reassembler_unit: PASSED **");
    end else begin
      $display("** byte_stream_reassembler_unit: FAILED **");
    end
    $finish;
  end

endmodule
